[hw/rtl/multi_stack_shared_memory_defines.svh]
`ifndef MULTI_STACK_SHARED_MEMORY_DEFINES_SVH
`define MULTI_STACK_SHARED_MEMORY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: consequent does not hold in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define MSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: consequent does not hold in the next cycle");

`endif

[hw/rtl/msm_pkg.sv]
package msm_pkg;

   localparam int DEPTH = 128;
   localparam int STACKS = 4;
   localparam int REGION = DEPTH / STACKS;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   localparam int FUNC_W = 3;
   localparam int SEL_W = 2;
   localparam int DATA_W = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W = 8;

   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 8;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 8;

   localparam logic [FUNC_W-1:0] OP_PUSH = 3'd0;
   localparam logic [FUNC_W-1:0] OP_POP = 3'd1;
   localparam logic [FUNC_W-1:0] OP_SHR = 3'd2;
   localparam logic [FUNC_W-1:0] OP_SHL = 3'd3;
   localparam logic [FUNC_W-1:0] OP_REINIT = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SH_RD,
      S_SH_WR,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic idx_init;
      logic shift_rd;
      logic move;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic shift_go;
      logic last_move;
      logic rsp_busy;
   } status_type;

   function automatic logic [FILL_W-1:0] region_base(input logic [SEL_W-1:0] k);
      return FILL_W'(int'(k) * REGION);
   endfunction

   function automatic logic [FILL_W-1:0] region_cap(input logic [SEL_W-1:0] k);
      if (int'(k) + 1 >= STACKS) begin
         return FILL_W'(DEPTH - int'(k) * REGION);
      end
      return FILL_W'(REGION);
   endfunction

endpackage

[hw/rtl/msm_ctrl.sv]
module msm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  msm_pkg::status_type  status,
   output msm_pkg::cmd_type     cmd,
   output logic                 req_tready
);

   msm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         msm_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = msm_pkg::S_DECODE;
            end
         end
         msm_pkg::S_DECODE: begin
            state_in = status.shift_go ? msm_pkg::S_SH_RD : msm_pkg::S_FINISH;
         end
         msm_pkg::S_SH_RD: begin
            state_in = msm_pkg::S_SH_WR;
         end
         msm_pkg::S_SH_WR: begin
            state_in = status.last_move ? msm_pkg::S_FINISH : msm_pkg::S_SH_RD;
         end
         msm_pkg::S_FINISH: begin
            if (!status.rsp_busy) begin
               state_in = msm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = msm_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         msm_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.capture = req_tvalid;
         end
         msm_pkg::S_DECODE: begin
            cmd.idx_init = 1'b1;
         end
         msm_pkg::S_SH_RD: begin
            cmd.shift_rd = 1'b1;
         end
         msm_pkg::S_SH_WR: begin
            cmd.move = 1'b1;
         end
         msm_pkg::S_FINISH: begin
            cmd.commit = !status.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[hw/rtl/msm_datapath.sv]
module msm_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [msm_pkg::FUNC_W-1:0]    func,
   input  logic [msm_pkg::SEL_W-1:0]     stack_select,
   input  logic [msm_pkg::DATA_W-1:0]    push_value,
   input  msm_pkg::cmd_type              cmd,
   output msm_pkg::status_type           status,
   input  logic                          rsp_tready,
   output logic                          rsp_valid,
   output logic [msm_pkg::DATA_W-1:0]    pop_data,
   output logic [msm_pkg::STATUS_W-1:0]  rsp_status,
   output logic [msm_pkg::COUNT_W-1:0]   fill_count,
   output logic                          is_empty,
   output logic                          is_full
);

   localparam int FW = msm_pkg::FILL_W;

   logic [msm_pkg::FUNC_W-1:0] op_ff;
   logic [msm_pkg::SEL_W-1:0] k_ff;
   logic [msm_pkg::DATA_W-1:0] value_ff;
   logic [FW-1:0] idx_ff;
   logic [FW-1:0] fill_ff [msm_pkg::STACKS];
   logic [msm_pkg::DATA_W-1:0] mem_ff [msm_pkg::DEPTH];
   logic [msm_pkg::DATA_W-1:0] rd_data_ff;

   logic rsp_valid_ff;
   logic [msm_pkg::DATA_W-1:0] rsp_data_ff;
   logic [msm_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [msm_pkg::COUNT_W-1:0] rsp_count_ff;
   logic rsp_empty_ff;
   logic rsp_full_ff;

   logic valid_k;
   logic [FW-1:0] fill_cur;
   logic [FW-1:0] base;
   logic [FW-1:0] cap;
   logic cur_full;
   logic cur_empty;
   logic [FW-1:0] top_addr;
   logic [FW-1:0] src_addr;
   logic [FW-1:0] dst_addr;
   logic [FW-1:0] rd_addr;
   logic wr_en;
   logic [FW-1:0] wr_addr;
   logic [msm_pkg::DATA_W-1:0] wr_data;
   logic [FW-1:0] fill_nxt;
   logic [msm_pkg::STATUS_W-1:0] status_nxt;
   logic [msm_pkg::DATA_W-1:0] data_nxt;
   logic is_right;

   assign valid_k = 32'(k_ff) < msm_pkg::STACKS;
   assign is_right = op_ff == msm_pkg::OP_SHR;

   always_comb begin
      fill_cur = '0;
      for (int j = 0; j < msm_pkg::STACKS; j++) begin
         if (32'(k_ff) == j) begin
            fill_cur = fill_ff[j];
         end
      end
   end

   assign base = msm_pkg::region_base(k_ff);
   assign cap = msm_pkg::region_cap(k_ff);
   assign cur_full = fill_cur >= cap;
   assign cur_empty = fill_cur == '0;

   assign top_addr = base + fill_cur - FW'(1);
   assign dst_addr = base + idx_ff;
   assign src_addr = is_right ? (dst_addr - FW'(1)) : (dst_addr + FW'(1));
   assign rd_addr = cmd.shift_rd ? src_addr : top_addr;

   always_comb begin
      status.shift_go = valid_k
         && ((is_right && !cur_full && !cur_empty)
         || (op_ff == msm_pkg::OP_SHL && fill_cur >= FW'(2)));
      status.last_move = is_right ? (idx_ff == FW'(1)) : ((idx_ff + FW'(2)) == fill_cur);
      status.rsp_busy = rsp_valid_ff && !rsp_tready;
   end

   always_comb begin
      fill_nxt = fill_cur;
      status_nxt = msm_pkg::ST_OK;
      data_nxt = '0;
      case (op_ff) inside
         msm_pkg::OP_PUSH, msm_pkg::OP_SHR: begin
            if (cur_full) begin
               status_nxt = msm_pkg::ST_FULL;
            end else begin
               fill_nxt = fill_cur + FW'(1);
            end
         end
         msm_pkg::OP_POP: begin
            if (cur_empty) begin
               status_nxt = msm_pkg::ST_EMPTY;
            end else begin
               fill_nxt = fill_cur - FW'(1);
               data_nxt = rd_data_ff;
            end
         end
         msm_pkg::OP_SHL: begin
            if (cur_empty) begin
               status_nxt = msm_pkg::ST_EMPTY;
            end else begin
               fill_nxt = fill_cur - FW'(1);
            end
         end
         msm_pkg::OP_REINIT: begin
            fill_nxt = '0;
         end
         default: begin
            fill_nxt = fill_cur;
         end
      endcase
      if (!valid_k) begin
         fill_nxt = '0;
         data_nxt = '0;
         status_nxt = (op_ff == msm_pkg::OP_REINIT) ? msm_pkg::ST_OK : msm_pkg::ST_EMPTY;
      end
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = dst_addr;
      wr_data = rd_data_ff;
      if (cmd.move) begin
         wr_en = 1'b1;
      end else if (cmd.commit && valid_k && op_ff == msm_pkg::OP_PUSH && !cur_full) begin
         wr_en = 1'b1;
         wr_addr = base + fill_cur;
         wr_data = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr[msm_pkg::ADDR_W-1:0]] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr[msm_pkg::ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= func;
         k_ff <= stack_select;
         value_ff <= push_value;
      end
      if (cmd.idx_init) begin
         idx_ff <= is_right ? fill_cur : '0;
      end else if (cmd.move) begin
         idx_ff <= is_right ? (idx_ff - FW'(1)) : (idx_ff + FW'(1));
      end
      if (cmd.commit) begin
         rsp_data_ff <= data_nxt;
         rsp_status_ff <= status_nxt;
         rsp_count_ff <= msm_pkg::COUNT_W'(fill_nxt);
         rsp_empty_ff <= !valid_k || fill_nxt == '0;
         rsp_full_ff <= valid_k && fill_nxt >= cap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < msm_pkg::STACKS; j++) begin
            fill_ff[j] <= '0;
         end
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.commit) begin
            for (int j = 0; j < msm_pkg::STACKS; j++) begin
               if (op_ff == msm_pkg::OP_REINIT) begin
                  fill_ff[j] <= '0;
               end else if (valid_k && 32'(k_ff) == j) begin
                  fill_ff[j] <= fill_nxt;
               end
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign pop_data = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign fill_count = rsp_count_ff;
   assign is_empty = rsp_empty_ff;
   assign is_full = rsp_full_ff;

endmodule

[hw/rtl/multi_stack_shared_memory.sv]
// Several stacks held in fixed regions of one shared element memory.
// Request channel (req_): tuser carries the operation and the stack number,
// tdata the value to push. Response channel (rsp_): tdata carries the popped
// value, the stack's fill count and its empty and full flags; tuser carries
// the status (ok, refused because full, refused because empty).
// One item is worked on at a time. Push, pop, reinit and refused operations
// pass from acceptance through a decode state to a finish state, where the
// response is registered, and the next item is taken once back in idle.
// A shift moves one entry at a time through the memory, reading it in the
// shift-read state and writing it in the shift-write state: a right shift
// moves fill entries, a left shift fill - 1.
// The response sits in an output register; a new item is taken while it
// waits, but that item's response is held back until the receiver takes
// the previous one, so nothing is lost when the receiver stalls.
// A synchronous reset empties every stack and drops any pending response;
// the memory contents are not cleared and a slot holds nothing defined
// until it has been written.
`include "multi_stack_shared_memory_defines.svh"

module multi_stack_shared_memory (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // push_value[31:0]
   input  logic [msm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // func[2:0], stack_select[4:3], zeros above
   input  logic [msm_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // pop_data[31:0], fill_count[39:32], is_empty[40], is_full[41], zeros above
   output logic [msm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status[1:0], zeros above
   output logic [msm_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   msm_pkg::cmd_type cmd;
   msm_pkg::status_type status;

   logic [msm_pkg::DATA_W-1:0] pop_data;
   logic [msm_pkg::STATUS_W-1:0] rsp_status;
   logic [msm_pkg::COUNT_W-1:0] fill_count;
   logic is_empty;
   logic is_full;

   msm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .cmd        (cmd),
      .req_tready (req_tready)
   );

   msm_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .func         (req_tuser[msm_pkg::FUNC_W-1:0]),
      .stack_select (req_tuser[msm_pkg::FUNC_W+msm_pkg::SEL_W-1:msm_pkg::FUNC_W]),
      .push_value   (req_tdata[msm_pkg::DATA_W-1:0]),
      .cmd          (cmd),
      .status       (status),
      .rsp_tready   (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .pop_data     (pop_data),
      .rsp_status   (rsp_status),
      .fill_count   (fill_count),
      .is_empty     (is_empty),
      .is_full      (is_full)
   );

   assign rsp_tdata = msm_pkg::RSP_DATA_W'({is_full, is_empty, fill_count, pop_data});
   assign rsp_tuser = msm_pkg::RSP_USER_W'(rsp_status);

   `MSM_ASSERT_NEXT(a_one_item_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
   `MSM_ASSERT_NEXT(a_commit_shows_response, clock, reset, cmd.commit, rsp_tvalid)
   `MSM_ASSERT_SAME(a_commit_not_over_pending, clock, reset, cmd.commit, !status.rsp_busy)
   `MSM_ASSERT_SAME(a_status_code_known, clock, reset, rsp_tvalid, rsp_status <= msm_pkg::ST_EMPTY)

endmodule
